// ===== hw/rtl/fdkhm_pkg.sv =====
// ----------------------------------------------------------------------------
// fdkhm_pkg: shared types and constants of the descriptor-keyed hash map
// Table geometry, field widths, command and status codes, and the slot layout
// that one memory row holds.
// ----------------------------------------------------------------------------
package fdkhm_pkg;

  // Table geometry.
  localparam int NUM_BUCKETS = 256;
  localparam int WAYS        = 4;
  localparam int BUCKET_W    = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;

  // Field widths.
  localparam int CMD_W    = 2;
  localparam int KEY_W    = 31;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 9;
  localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

  // Hash arithmetic: sdbm multiplies by 65599 as (h << 6) + (h << 16) - h.
  localparam int HASH_W        = 32;
  localparam int BYTE_W        = 8;
  localparam int HASH_SHIFT_LO = 6;
  localparam int HASH_SHIFT_HI = 16;
  localparam int HASH_STEPS    = HASH_W / BYTE_W;
  localparam int MOD_BITS      = 8;
  localparam int MOD_STEPS     = HASH_W / MOD_BITS;
  localparam int STEP_W        = 2;
  localparam int DIV_W         = (CFG_W > BUCKET_W + 1) ? CFG_W : BUCKET_W + 1;

  // Request commands.
  typedef enum logic [CMD_W-1:0] {
    CMD_GET = 2'd0,
    CMD_SET = 2'd1,
    CMD_DEL = 2'd2
  } cmd_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  // One slot of a bucket, and a whole bucket as one memory row.
  typedef struct packed {
    logic               valid;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);
  localparam int ROW_W  = WAYS * SLOT_W;

  typedef slot_t [WAYS-1:0] row_t;

  // Result of the hash and modulo unit.
  typedef struct packed {
    logic                done;
    logic [BUCKET_W-1:0] bucket;
  } hash_res_t;

endpackage

// ===== hw/rtl/fdkhm_if.sv =====
// ----------------------------------------------------------------------------
// fdkhm_if: request and response channels of the hash map
// Valid/ready channels; an item moves on a clock edge with valid and ready high.
// ----------------------------------------------------------------------------
interface fdkhm_req_if;
  logic                          valid;
  logic                          ready;
  logic [fdkhm_pkg::CMD_W-1:0]   command;
  logic [fdkhm_pkg::KEY_W-1:0]   key;
  logic [fdkhm_pkg::VALUE_W-1:0] value;

  modport source (output valid, command, key, value, input ready);
  modport sink   (input valid, command, key, value, output ready);
endinterface

interface fdkhm_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [fdkhm_pkg::STATUS_W-1:0] status;
  logic [fdkhm_pkg::VALUE_W-1:0]  value_out;

  modport source (output valid, status, value_out, input ready);
  modport sink   (input valid, status, value_out, output ready);
endinterface

// ===== hw/rtl/fd_keyed_hash_map.sv =====
// ----------------------------------------------------------------------------
// fd_keyed_hash_map: descriptor-keyed hash map with fixed-size buckets
// Get, set and delete requests on a table of NUM_BUCKETS buckets of WAYS
// slots, each bucket held as one row of a synchronous RAM.
// ----------------------------------------------------------------------------
// After reset the block clears all NUM_BUCKETS (256) rows of the bucket
// memory, one row per cycle, and takes no request during that time; bucket
// count writes are taken at any time. It then handles one request at a time:
// the sdbm hash folds one key byte per cycle, then the modulo by the bucket
// count takes 8 dividend bits per cycle, then the bucket row is read, and
// it is written back once the output register can take the result (the
// register is empty or being emptied); ready rises again in the cycle
// after the write. The result is held in an output register, so a new request
// is taken while the previous result waits; a request stalls in its last cycle
// only while an older result has not been taken. The bucket count may be
// changed only while the block is idle, and entries are not moved when it
// changes.
// ----------------------------------------------------------------------------
module fd_keyed_hash_map (
  input  logic                        clk,
  input  logic                        rst,
  fdkhm_req_if.sink                   req,
  fdkhm_rsp_if.source                 rsp,
  input  logic                        cfg_wr_en,
  input  logic [fdkhm_pkg::CFG_W-1:0] cfg_wr_data
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_LOOKUP
  } state_t;

  state_t                           state;
  logic [fdkhm_pkg::BUCKET_W-1:0]   clr_addr;
  logic [fdkhm_pkg::CFG_W-1:0]      bucket_count;
  fdkhm_pkg::cmd_t                  cur_cmd;
  logic [fdkhm_pkg::KEY_W-1:0]      cur_key;
  logic [fdkhm_pkg::VALUE_W-1:0]    cur_value;
  logic [fdkhm_pkg::BUCKET_W-1:0]   cur_bucket;
  fdkhm_pkg::hash_res_t             hash_res;
  logic                             accept;
  logic                             advance;
  logic                             rd_en;
  logic                             wr_en;
  logic [fdkhm_pkg::BUCKET_W-1:0]   wr_addr;
  logic [fdkhm_pkg::ROW_W-1:0]      wr_data;
  logic [fdkhm_pkg::ROW_W-1:0]      rd_data;
  fdkhm_pkg::row_t                  row_rd;
  fdkhm_pkg::row_t                  row_new;
  logic [fdkhm_pkg::WAYS-1:0]       hit_oh;
  logic [fdkhm_pkg::WAYS-1:0]       free_oh;
  fdkhm_pkg::status_t               res_status;
  logic [fdkhm_pkg::VALUE_W-1:0]    res_value;

  // Bucket count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count <= fdkhm_pkg::CFG_RESET;
    end else if (cfg_wr_en) begin
      bucket_count <= cfg_wr_data;
    end
  end

  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign advance   = (state == ST_LOOKUP) && (!rsp.valid || rsp.ready);

  // Hash and modulo unit.
  fdkhm_hash u_hash (
    .clk          (clk),
    .rst          (rst),
    .start        (accept),
    .key          (req.key),
    .bucket_count (bucket_count),
    .res          (hash_res)
  );

  // Bucket memory: one row per bucket.
  assign rd_en   = (state == ST_HASH) && hash_res.done;
  assign wr_en   = (state == ST_CLEAR) || advance;
  assign wr_addr = (state == ST_CLEAR) ? clr_addr : cur_bucket;
  assign wr_data = (state == ST_CLEAR) ? '0 : fdkhm_pkg::ROW_W'(row_new);
  assign row_rd  = fdkhm_pkg::row_t'(rd_data);

  fdkhm_ram #(
    .WIDTH (fdkhm_pkg::ROW_W),
    .DEPTH (fdkhm_pkg::NUM_BUCKETS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (hash_res.bucket),
    .rd_data (rd_data)
  );

  // Slot scan: first valid slot with the key, and lowest free slot.
  always_comb begin
    logic seen_hit;
    logic seen_free;
    hit_oh    = '0;
    free_oh   = '0;
    seen_hit  = 1'b0;
    seen_free = 1'b0;
    for (int w = 0; w < fdkhm_pkg::WAYS; w++) begin
      if (row_rd[w].valid) begin
        if (!seen_hit && row_rd[w].key == cur_key) begin
          hit_oh[w] = 1'b1;
          seen_hit  = 1'b1;
        end
      end else if (!seen_free) begin
        free_oh[w] = 1'b1;
        seen_free  = 1'b1;
      end
    end
  end

  // Row update and result for the current command.
  always_comb begin
    row_new    = row_rd;
    res_status = fdkhm_pkg::ST_MISS;
    res_value  = '0;
    case (cur_cmd)
      fdkhm_pkg::CMD_GET: begin
        if (hit_oh != '0) begin
          res_status = fdkhm_pkg::ST_OK;
          for (int w = 0; w < fdkhm_pkg::WAYS; w++) begin
            if (hit_oh[w]) begin
              res_value = row_rd[w].value;
            end
          end
        end
      end
      fdkhm_pkg::CMD_SET: begin
        if (hit_oh != '0) begin
          res_status = fdkhm_pkg::ST_OK;
          for (int w = 0; w < fdkhm_pkg::WAYS; w++) begin
            if (hit_oh[w]) begin
              row_new[w].value = cur_value;
            end
          end
        end else if (free_oh != '0) begin
          res_status = fdkhm_pkg::ST_OK;
          for (int w = 0; w < fdkhm_pkg::WAYS; w++) begin
            if (free_oh[w]) begin
              row_new[w].valid = 1'b1;
              row_new[w].key   = cur_key;
              row_new[w].value = cur_value;
            end
          end
        end else begin
          res_status = fdkhm_pkg::ST_FULL;
        end
      end
      fdkhm_pkg::CMD_DEL: begin
        if (hit_oh != '0) begin
          res_status = fdkhm_pkg::ST_OK;
          for (int w = 0; w < fdkhm_pkg::WAYS; w++) begin
            if (hit_oh[w]) begin
              row_new[w].valid = 1'b0;
            end
          end
        end
      end
      default: begin
        res_status = fdkhm_pkg::ST_MISS;
      end
    endcase
  end

  // Sequencer, request registers and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      rsp.valid <= 1'b0;
    end else begin
      // A taken result empties the register unless a new one replaces it.
      if (rsp.valid && rsp.ready && !advance) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == fdkhm_pkg::BUCKET_W'(fdkhm_pkg::NUM_BUCKETS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            cur_cmd   <= fdkhm_pkg::cmd_t'(req.command);
            cur_key   <= req.key;
            cur_value <= req.value;
            state     <= ST_HASH;
          end
        end
        ST_HASH: begin
          if (hash_res.done) begin
            cur_bucket <= hash_res.bucket;
            state      <= ST_LOOKUP;
          end
        end
        ST_LOOKUP: begin
          if (advance) begin
            rsp.valid     <= 1'b1;
            rsp.status    <= res_status;
            rsp.value_out <= res_value;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // The sequencer takes one request at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    accept |=> !req.ready)
    else $error("request accepted while another is in flight");

  // The hash unit reports only while a request waits for it.
  a_hash_done_state: assert property (@(posedge clk) disable iff (rst)
    hash_res.done |-> state == ST_HASH)
    else $error("hash result with no request waiting");

  // A bucket row is never read and written in the same cycle.
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(rd_en && wr_en))
    else $error("bucket row read and written together");

  // Only a successful get returns a handle.
  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status != fdkhm_pkg::ST_OK |-> rsp.value_out == '0)
    else $error("handle returned on a failed request");

  // No result appears during the clearing pass.
  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> !rsp.valid && !req.ready)
    else $error("activity during clearing pass");

endmodule

// ===== hw/rtl/fdkhm_ram.sv =====
// ----------------------------------------------------------------------------
// fdkhm_ram: generic single-port-write, single-port-read synchronous RAM
// One write and one read per cycle; read data is registered and holds
// until the next read.
// ----------------------------------------------------------------------------
module fdkhm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                         clk,
  input  logic                                         wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                             wr_data,
  input  logic                                         rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                             rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/fdkhm_hash.sv =====
// ----------------------------------------------------------------------------
// fdkhm_hash: iterative sdbm hash and bucket modulo unit
// Folds one key byte per cycle into the hash, then reduces the 31-bit hash
// modulo the bucket count, eight dividend bits per cycle.
// ----------------------------------------------------------------------------
module fdkhm_hash (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [fdkhm_pkg::KEY_W-1:0]     key,
  input  logic [fdkhm_pkg::CFG_W-1:0]     bucket_count,
  output fdkhm_pkg::hash_res_t            res
);

  typedef enum logic [1:0] {
    H_IDLE,
    H_HASH,
    H_MOD,
    H_DONE
  } hstate_t;

  hstate_t                          state;
  logic [fdkhm_pkg::STEP_W-1:0]     step;
  logic [fdkhm_pkg::HASH_W-1:0]     kbytes;
  logic [fdkhm_pkg::HASH_W-1:0]     hash;
  logic [fdkhm_pkg::HASH_W-1:0]     hash_next;
  logic [fdkhm_pkg::BUCKET_W-1:0]   rem;
  logic [fdkhm_pkg::DIV_W-1:0]      rem_next;
  logic [fdkhm_pkg::DIV_W-1:0]      divisor;

  // Bucket count in use: zero counts as one, and it never exceeds the table.
  always_comb begin
    if (bucket_count == '0) begin
      divisor = fdkhm_pkg::DIV_W'(1);
    end else if (32'(bucket_count) > 32'(fdkhm_pkg::NUM_BUCKETS)) begin
      divisor = fdkhm_pkg::DIV_W'(fdkhm_pkg::NUM_BUCKETS);
    end else begin
      divisor = fdkhm_pkg::DIV_W'(bucket_count);
    end
  end

  // One sdbm step: sign-extended byte plus hash times 65599.
  always_comb begin
    logic [fdkhm_pkg::HASH_W-1:0] byte_ext;
    byte_ext  = {{(fdkhm_pkg::HASH_W - fdkhm_pkg::BYTE_W){kbytes[fdkhm_pkg::BYTE_W-1]}},
                 kbytes[fdkhm_pkg::BYTE_W-1:0]};
    hash_next = byte_ext + (hash << fdkhm_pkg::HASH_SHIFT_LO)
              + (hash << fdkhm_pkg::HASH_SHIFT_HI) - hash;
  end

  // Restoring remainder over the top dividend bits; the remainder stays
  // below the divisor, so each shift fits in DIV_W bits.
  always_comb begin
    logic [fdkhm_pkg::DIV_W-1:0] r;
    r = fdkhm_pkg::DIV_W'(rem);
    for (int i = 0; i < fdkhm_pkg::MOD_BITS; i++) begin
      r = {r[fdkhm_pkg::DIV_W-2:0], hash[fdkhm_pkg::HASH_W-1-i]};
      if (r >= divisor) begin
        r = r - divisor;
      end
    end
    rem_next = r;
  end

  // Sequencer: four hash steps, then four modulo steps, then the done state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= H_IDLE;
      step  <= '0;
    end else begin
      case (state)
        H_IDLE: begin
          if (start) begin
            kbytes <= {1'b0, key};
            hash   <= '0;
            step   <= '0;
            state  <= H_HASH;
          end
        end
        H_HASH: begin
          kbytes <= kbytes >> fdkhm_pkg::BYTE_W;
          if (step == fdkhm_pkg::STEP_W'(fdkhm_pkg::HASH_STEPS - 1)) begin
            // The top bit of the hash is masked off before the modulo.
            hash  <= {1'b0, hash_next[fdkhm_pkg::HASH_W-2:0]};
            step  <= '0;
            rem   <= '0;
            state <= H_MOD;
          end else begin
            hash <= hash_next;
            step <= step + 1'b1;
          end
        end
        H_MOD: begin
          hash <= hash << fdkhm_pkg::MOD_BITS;
          rem  <= fdkhm_pkg::BUCKET_W'(rem_next);
          step <= step + 1'b1;
          if (step == fdkhm_pkg::STEP_W'(fdkhm_pkg::MOD_STEPS - 1)) begin
            state <= H_DONE;
          end
        end
        H_DONE: begin
          state <= H_IDLE;
        end
        default: begin
          state <= H_IDLE;
        end
      endcase
    end
  end

  assign res.done   = (state == H_DONE);
  assign res.bucket = rem;

endmodule
